[rtl/b128sm_pkg.sv]
// Package: payload types and constants for the binary128 scale multiplier.
`timescale 1ns / 1ps
`default_nettype none
package b128sm_pkg;

    localparam int unsigned EXPONENT_OFFSET = 16'h3FFF;
    localparam int unsigned EXP_MAX     = 16'h7FFF;
    localparam int unsigned SHIFT_LIMIT = 114;

    localparam logic [63:0] INF_HIGH  = 64'h7FFF_0000_0000_0000;
    localparam logic [63:0] QNAN_HIGH = 64'h7FFF_8000_0000_0000;

    localparam logic [1:0] REG_FACTOR_HIGH = 2'd0;
    localparam logic [1:0] REG_FACTOR_LOW  = 2'd1;

    typedef struct packed {
        logic [63:0] operand_high;
        logic [63:0] operand_low;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [63:0] product_high;
        logic [63:0] product_low;
        logic        last_out;
    } out_item_t;

    // result class decided up front
    typedef enum logic [1:0] {
        CLS_NUM  = 2'd0,
        CLS_PASS = 2'd1,
        CLS_INF  = 2'd2,
        CLS_ZERO = 2'd3
    } cls_t;

    // stage 1 -> multiplier
    typedef struct packed {
        cls_t          cls;
        logic [63:0]   pass_high;
        logic [63:0]   pass_low;
        logic          sign;
        logic          last;
        logic signed [17:0] exp_sum;
    } ctl_t;

endpackage
`default_nettype wire

[rtl/b128sm_unpack.sv]
// Stage 1: classify operands and normalize mantissas.
`timescale 1ns / 1ps
`default_nettype none
module b128sm_unpack
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire b128sm_pkg::in_item_t in_item,
    input  wire logic [63:0]          factor_high,
    input  wire logic [63:0]          factor_low,
    output logic                      out_valid,
    output b128sm_pkg::ctl_t          ctl,
    output logic [112:0]              mant_x,
    output logic [112:0]              mant_y
);

    logic valid_reg;
    b128sm_pkg::ctl_t ctl_reg, ctl_next;
    logic [112:0] mx_reg, my_reg, mx_next, my_next;

    function automatic logic [6:0] lead_zeros(input logic [112:0] m);
        logic [6:0] n;
        logic       found;
        n = 7'd0;
        found = 1'b0;
        for (int i = 112; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                found = 1'b1;
                n = 7'(112 - i);
            end
        end
        return n;
    endfunction

    logic [14:0] fe, oe;
    logic        f_mant, o_mant, f_zero, o_zero, sign;
    logic [112:0] fm_raw, om_raw;
    logic [6:0]   flz, olz;
    logic signed [17:0] fexp, oexp;

    always_comb
    begin
        fe = factor_high[62:48];
        oe = in_item.operand_high[62:48];
        f_mant = (factor_high[47:0] != '0) || (factor_low != '0);
        o_mant = (in_item.operand_high[47:0] != '0) || (in_item.operand_low != '0);
        f_zero = (fe == '0) && !f_mant;
        o_zero = (oe == '0) && !o_mant;
        sign = factor_high[63] ^ in_item.operand_high[63];
        fm_raw = {(fe != '0), factor_high[47:0], factor_low};
        om_raw = {(oe != '0), in_item.operand_high[47:0], in_item.operand_low};
        flz = lead_zeros(fm_raw);
        olz = lead_zeros(om_raw);
        fexp = (fe != '0) ? 18'(fe) : 18'sd1 - 18'(flz);
        oexp = (oe != '0) ? 18'(oe) : 18'sd1 - 18'(olz);
        mx_next = fm_raw << flz;
        my_next = om_raw << olz;

        ctl_next.sign = sign;
        ctl_next.last = in_item.last_element;
        ctl_next.exp_sum = fexp + oexp - 18'(b128sm_pkg::EXPONENT_OFFSET);
        ctl_next.pass_high = factor_high;
        ctl_next.pass_low = factor_low;
        if (fe == 15'(b128sm_pkg::EXP_MAX) && f_mant)
        begin
            ctl_next.cls = b128sm_pkg::CLS_PASS;
        end
        else if (oe == 15'(b128sm_pkg::EXP_MAX) && o_mant)
        begin
            ctl_next.cls = b128sm_pkg::CLS_PASS;
            ctl_next.pass_high = in_item.operand_high;
            ctl_next.pass_low = in_item.operand_low;
        end
        else if (fe == 15'(b128sm_pkg::EXP_MAX) || oe == 15'(b128sm_pkg::EXP_MAX))
        begin
            ctl_next.cls = b128sm_pkg::CLS_PASS;
            ctl_next.pass_high = (f_zero || o_zero) ? b128sm_pkg::QNAN_HIGH
                                 : ({sign, 63'd0} | b128sm_pkg::INF_HIGH);
            ctl_next.pass_low = '0;
        end
        else if (f_zero || o_zero)
        begin
            ctl_next.cls = b128sm_pkg::CLS_ZERO;
        end
        else
        begin
            ctl_next.cls = b128sm_pkg::CLS_NUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
    end

    assign out_valid = valid_reg;
    assign ctl = ctl_reg;
    assign mant_x = mx_reg;
    assign mant_y = my_reg;

endmodule
`default_nettype wire

[rtl/b128sm_mult.sv]
// Pipelined 113x113 mantissa multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module b128sm_mult
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire b128sm_pkg::ctl_t in_ctl,
    input  wire logic [112:0]     mant_x,
    input  wire logic [112:0]     mant_y,
    output logic                  out_valid,
    output b128sm_pkg::ctl_t      out_ctl,
    output logic [225:0]          product
);

    // 4 limbs of 32 bits; top limb holds 17 bits
    logic [127:0] xw, yw;
    assign xw = {15'd0, mant_x};
    assign yw = {15'd0, mant_y};

    logic [63:0] pp_reg [16];
    logic [1:0]  v_reg;
    b128sm_pkg::ctl_t c1_reg, c2_reg;
    logic [255:0] row_reg [4];
    logic [255:0] sum_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pp_reg[i*4+j] <= xw[i*32 +: 32] * yw[j*32 +: 32];
            end
        end
        c1_reg <= in_ctl;
        for (int i = 0; i < 4; i++)
        begin
            row_reg[i] <= (256'(pp_reg[i*4+0]) << (i*32))
                        + (256'(pp_reg[i*4+1]) << (i*32 + 32))
                        + (256'(pp_reg[i*4+2]) << (i*32 + 64))
                        + (256'(pp_reg[i*4+3]) << (i*32 + 96));
        end
        c2_reg <= c1_reg;
        sum_reg <= (row_reg[0] + row_reg[1]) + (row_reg[2] + row_reg[3]);
        out_ctl <= c2_reg;
    end

    logic v3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v_reg <= {v_reg[0], in_valid};
            v3_reg <= v_reg[1];
        end
    end

    assign out_valid = v3_reg;
    assign product = sum_reg[225:0];

endmodule
`default_nettype wire

[rtl/b128sm_round.sv]
// Normalize, shift for subnormals, round to nearest even and pack.
`timescale 1ns / 1ps
`default_nettype none
module b128sm_round
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire b128sm_pkg::ctl_t in_ctl,
    input  wire logic [225:0]     product,
    output logic                  out_valid,
    output b128sm_pkg::out_item_t out_item
);

    // stage A: shift amount and sticky
    logic        va_reg;
    b128sm_pkg::ctl_t ca_reg;
    logic [113:0] kept_reg;
    logic        half_reg, sticky_reg, zero_reg, ovf_reg;
    logic [14:0] ebase_reg;

    logic        msbit;
    logic signed [18:0] e;
    logic [7:0]  sh;
    logic        zero_n, ovf_n;
    logic [14:0] ebase_n;
    logic [226:0] shifted;
    logic [225:0] below_mask;
    logic signed [18:0] rs;

    always_comb
    begin
        msbit = product[225];
        e = 19'(in_ctl.exp_sum) + 19'(msbit);
        ovf_n = e >= 19'sd32767;
        zero_n = 1'b0;
        ebase_n = '0;
        sh = 8'd112 + 8'(msbit);
        rs = 19'(msbit) + 19'sd1 - e;
        if (e <= 19'sd0)
        begin
            if (rs > 19'sd114)
            begin
                zero_n = 1'b1;
            end
            else
            begin
                sh = 8'd112 + 8'(rs);
            end
        end
        else
        begin
            ebase_n = 15'(e - 19'sd1);
        end
        shifted = {1'b0, product} >> (sh - 8'd1);
        below_mask = ~({226{1'b1}} << (sh - 8'd1));
    end

    always_ff @(posedge clk)
    begin
        ca_reg <= in_ctl;
        kept_reg <= shifted[114:1];
        half_reg <= shifted[0];
        sticky_reg <= (product & below_mask) != '0;
        zero_reg <= zero_n;
        ovf_reg <= ovf_n;
        ebase_reg <= ebase_n;
    end

    // stage B: round and pack
    logic [127:0] mant, rounded, packed_v;
    b128sm_pkg::out_item_t res;
    always_comb
    begin
        mant = 128'(kept_reg);
        rounded = mant + 128'(half_reg && (sticky_reg || kept_reg[0]));
        packed_v = rounded + {1'b0, ebase_reg, 112'd0};
        res.last_out = ca_reg.last;
        res.product_high = {ca_reg.sign, 63'd0};
        res.product_low = '0;
        case (ca_reg.cls)
            b128sm_pkg::CLS_PASS:
            begin
                res.product_high = ca_reg.pass_high;
                res.product_low = ca_reg.pass_low;
            end
            b128sm_pkg::CLS_ZERO:
            begin
            end
            b128sm_pkg::CLS_NUM:
            begin
                if (ovf_reg)
                begin
                    res.product_high = {ca_reg.sign, 63'd0} | b128sm_pkg::INF_HIGH;
                end
                else if (!zero_reg)
                begin
                    res.product_high = packed_v[127:64] | {ca_reg.sign, 63'd0};
                    res.product_low = packed_v[63:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    logic vb_reg;
    always_ff @(posedge clk)
    begin
        out_item <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign out_valid = vb_reg;

endmodule
`default_nettype wire

[rtl/binary128_scale_multiply.sv]
// Top level: binary128 multiply of a stream by a configured factor.
// One element may start in every cycle (busy is always low); each product
// appears on result with done high after its start transfer has gone through
// one unpack stage, three multiplier stages (32x32 partial products, row sums,
// final add), one rounding stage (shift and sticky) and the output register
// (round and pack). The receiver cannot stall: each result is valid for one
// cycle only. The factor is set through the APB port (factor_high at 0x0,
// factor_low at 0x8) while idle.
`timescale 1ns / 1ps
`default_nettype none
module binary128_scale_multiply
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  wire logic                  start,
    input  wire b128sm_pkg::in_item_t  operand,
    output logic                       busy,
    output logic                       done,
    output b128sm_pkg::out_item_t      result
);

    logic [63:0] factor_high_reg, factor_low_reg;
    logic        wr;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign idx = paddr[3] ? b128sm_pkg::REG_FACTOR_LOW : b128sm_pkg::REG_FACTOR_HIGH;
    assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_high_reg <= '0;
            factor_low_reg <= '0;
        end
        else if (wr)
        begin
            if (idx == b128sm_pkg::REG_FACTOR_HIGH)
            begin
                factor_high_reg <= pwdata;
            end
            else
            begin
                factor_low_reg <= pwdata;
            end
        end
    end

    assign prdata = (idx == b128sm_pkg::REG_FACTOR_HIGH) ? factor_high_reg : factor_low_reg;

    logic             v1, v2, v3;
    b128sm_pkg::ctl_t c1, c2;
    logic [112:0]     mx, my;
    logic [225:0]     prod;
    b128sm_pkg::out_item_t res;

    b128sm_unpack u_unpack
    (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_item(operand),
        .factor_high(factor_high_reg), .factor_low(factor_low_reg),
        .out_valid(v1), .ctl(c1), .mant_x(mx), .mant_y(my)
    );

    b128sm_mult u_mult
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_ctl(c1),
        .mant_x(mx), .mant_y(my), .out_valid(v2), .out_ctl(c2), .product(prod)
    );

    b128sm_round u_round
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .in_ctl(c2), .product(prod),
        .out_valid(v3), .out_item(res)
    );

    assign done = v3;
    assign result = res;

endmodule
`default_nettype wire
